FILE: hdl/priority_ready_queue_dispatcher_core_assert.svh
// Assertion macros for the ready queue dispatcher.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef PRIORITY_READY_QUEUE_DISPATCHER_CORE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_DISPATCHER_CORE_ASSERT_SVH

// Same-cycle implication
`define PRQD_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PRQD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/prqd_pkg.sv
// Package for the ready queue dispatcher: sizes, codes and the list entry type.
// No dependencies.
`default_nettype none

package prqd_pkg;

    // Sizing
    localparam int TASK_COUNT = 16;
    localparam int PRIO_BITS  = 8;
    localparam int TASK_W     = $clog2(TASK_COUNT);
    localparam int CNT_W      = $clog2(TASK_COUNT + 1);
    localparam int LIST_DEPTH = 1 << TASK_W;

    // Request codes
    typedef enum logic [1:0] {
        FN_ACTIVATE = 2'd0,
        FN_REMOVE   = 2'd1,
        FN_DISPATCH = 2'd2,
        FN_LEAVE    = 2'd3
    } func_t;

    // Task status, suspended on reset
    typedef enum logic [1:0] {
        ST_SUSPENDED = 2'd0,
        ST_READY     = 2'd1,
        ST_RUNNING   = 2'd2
    } status_t;

    // One ready list entry: task and its priority kept side by side
    typedef struct packed {
        logic [TASK_W-1:0]    id;
        logic [PRIO_BITS-1:0] prio;
    } entry_t;

endpackage

`default_nettype wire

FILE: hdl/priority_ready_queue_dispatcher_core.sv
// Ready queue of a preemptive fixed-priority scheduler, one request at a time.
// The ready list is a circular buffer in a single memory (one read, one write port,
// registered read) holding task id and priority per entry, kept sorted by ascending
// priority with equal priorities in insertion order; task status sits in flops and
// the running task with its priority in registers. Dispatch pops the head by moving
// the head pointer. Activate walks from the tail moving one entry a cycle; a
// preempting dispatch requeues the old task the same way. Remove scans and closes
// the gap one entry a cycle. The last step of a request holds for as long as the
// previous result is still stalled on the result channel. Every request gives
// exactly one result; no clearing pass after reset.
// Depends on prqd_pkg and priority_ready_queue_dispatcher_core_assert.svh.
`default_nettype none

`include "priority_ready_queue_dispatcher_core_assert.svh"

module priority_ready_queue_dispatcher_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_wdata,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     func,
    input  wire logic [prqd_pkg::TASK_W-1:0]    task_id,
    input  wire logic [prqd_pkg::PRIO_BITS-1:0] priority_req,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [prqd_pkg::TASK_W-1:0]         current_task,
    output logic                                current_valid,
    output logic                                switched,
    output logic                                preempted,
    output logic [prqd_pkg::TASK_W-1:0]         preempted_task,
    output logic                                accepted,
    output logic [prqd_pkg::CNT_W-1:0]          ready_count
);

    localparam int TW = prqd_pkg::TASK_W;
    localparam int CW = prqd_pkg::CNT_W;
    localparam int PW = prqd_pkg::PRIO_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PLACE,
        S_REM,
        S_HEAD,
        S_DONE
    } state_t;

    // Sequencer and scheduler state
    state_t                   state_reg, state_next;
    logic                     en_reg;
    prqd_pkg::func_t          func_reg, func_next;
    logic [TW-1:0]            tid_reg, tid_next;
    logic [TW-1:0]            head_reg, head_next;
    logic [CW-1:0]            len_reg, len_next;
    logic [CW-1:0]            pos_reg, pos_next;
    logic                     found_reg, found_next;
    prqd_pkg::entry_t         ins_reg, ins_next;
    prqd_pkg::status_t        status_reg [prqd_pkg::TASK_COUNT];
    prqd_pkg::status_t        status_next [prqd_pkg::TASK_COUNT];
    logic [TW-1:0]            run_id_reg, run_id_next;
    logic [PW-1:0]            run_prio_reg, run_prio_next;
    logic                     run_valid_reg, run_valid_next;
    logic                     sw_reg, sw_next;
    logic                     pre_reg, pre_next;
    logic [TW-1:0]            pre_id_reg, pre_id_next;
    logic                     acc_reg, acc_next;

    // Result register
    logic                     out_valid_reg, out_valid_next;
    logic [TW-1:0]            cur_task_reg, cur_task_next;
    logic                     cur_valid_reg, cur_valid_next;
    logic                     switched_reg, switched_next;
    logic                     preempted_reg, preempted_next;
    logic [TW-1:0]            pre_task_reg, pre_task_next;
    logic                     accepted_reg, accepted_next;
    logic [CW-1:0]            count_reg, count_next;

    // List memory ports
    prqd_pkg::entry_t         list_mem [prqd_pkg::LIST_DEPTH];
    prqd_pkg::entry_t         rd_data_reg;
    logic [TW-1:0]            rd_addr;
    logic                     wr_en;
    logic [TW-1:0]            wr_addr;
    prqd_pkg::entry_t         wr_data;

    // Helpers
    logic [CW-1:0]            len_m1, pos_m1, pos_m2, pos_p1;
    logic                     tid_ok;
    logic                     rem_match;
    logic                     go;
    logic                     preempt;

    assign len_m1    = len_reg - CW'(1);
    assign pos_m1    = pos_reg - CW'(1);
    assign pos_m2    = pos_reg - CW'(2);
    assign pos_p1    = pos_reg + CW'(1);
    assign tid_ok    = CW'(task_id) < CW'(prqd_pkg::TASK_COUNT);
    assign rem_match = !found_reg && (rd_data_reg.id == tid_reg);

    // Head decision for dispatch and leave-interrupt
    always_comb
    begin
        if (func_reg == prqd_pkg::FN_DISPATCH)
            go = !(run_valid_reg && rd_data_reg.id == run_id_reg);
        else
            go = !run_valid_reg ||
                 (rd_data_reg.id != run_id_reg && rd_data_reg.prio < run_prio_reg);
        preempt = run_valid_reg && status_reg[run_id_reg] == prqd_pkg::ST_RUNNING;
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        tid_next       = tid_reg;
        head_next      = head_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        ins_next       = ins_reg;
        status_next    = status_reg;
        run_id_next    = run_id_reg;
        run_prio_next  = run_prio_reg;
        run_valid_next = run_valid_reg;
        sw_next        = sw_reg;
        pre_next       = pre_reg;
        pre_id_next    = pre_id_reg;
        acc_next       = acc_reg;

        out_valid_next = out_valid_reg;
        cur_task_next  = cur_task_reg;
        cur_valid_next = cur_valid_reg;
        switched_next  = switched_reg;
        preempted_next = preempted_reg;
        pre_task_next  = pre_task_reg;
        accepted_next  = accepted_reg;
        count_next     = count_reg;

        rd_addr = head_reg;
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = ins_reg;

        // result leaves on a transfer
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = prqd_pkg::func_t'(func);
                    tid_next    = task_id;
                    sw_next     = 1'b0;
                    pre_next    = 1'b0;
                    pre_id_next = '0;
                    acc_next    = 1'b0;
                    state_next  = S_DONE;
                    unique case (prqd_pkg::func_t'(func)) inside
                        prqd_pkg::FN_ACTIVATE:
                        begin
                            if (en_reg && tid_ok &&
                                status_reg[task_id] == prqd_pkg::ST_SUSPENDED &&
                                len_reg < CW'(prqd_pkg::TASK_COUNT))
                            begin
                                status_next[task_id] = prqd_pkg::ST_READY;
                                acc_next     = 1'b1;
                                ins_next.id  = task_id;
                                ins_next.prio = priority_req;
                                pos_next     = len_reg;
                                rd_addr      = head_reg + len_m1[TW-1:0];
                                state_next   = (len_reg == '0) ? S_PLACE : S_INS;
                            end
                        end
                        prqd_pkg::FN_REMOVE:
                        begin
                            if (tid_ok && len_reg != '0)
                            begin
                                pos_next   = '0;
                                found_next = 1'b0;
                                rd_addr    = head_reg;
                                state_next = S_REM;
                            end
                        end
                        prqd_pkg::FN_DISPATCH, prqd_pkg::FN_LEAVE:
                        begin
                            if (len_reg != '0)
                            begin
                                rd_addr    = head_reg;
                                state_next = S_HEAD;
                            end
                            else if (prqd_pkg::func_t'(func) == prqd_pkg::FN_DISPATCH)
                            begin
                                run_valid_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // walk from the tail, moving worse-priority entries up by one
            S_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = head_reg + pos_reg[TW-1:0];
                if (rd_data_reg.prio > ins_reg.prio)
                begin
                    wr_data  = rd_data_reg;
                    pos_next = pos_m1;
                    rd_addr  = head_reg + pos_m2[TW-1:0];
                    if (pos_m1 == '0)
                        state_next = S_PLACE;
                end
                else
                begin
                    wr_data    = ins_reg;
                    len_next   = len_reg + CW'(1);
                    state_next = S_DONE;
                end
            end

            // new entry lands at the front
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = head_reg + pos_reg[TW-1:0];
                wr_data    = ins_reg;
                len_next   = len_reg + CW'(1);
                state_next = S_DONE;
            end

            // scan for the task, then close the gap one entry a cycle
            S_REM:
            begin
                wr_en      = found_reg;
                wr_addr    = head_reg + pos_m1[TW-1:0];
                wr_data    = rd_data_reg;
                found_next = found_reg || rem_match;
                if (pos_p1 < len_reg)
                begin
                    pos_next = pos_p1;
                    rd_addr  = head_reg + pos_p1[TW-1:0];
                end
                else
                begin
                    if (found_reg || rem_match)
                    begin
                        len_next = len_m1;
                        acc_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end

            // head entry is in: if it may run, pop it and requeue a preempted task
            S_HEAD:
            begin
                state_next = S_DONE;
                if (go)
                begin
                    if (preempt)
                    begin
                        status_next[run_id_reg] = prqd_pkg::ST_READY;
                        pre_next      = 1'b1;
                        pre_id_next   = run_id_reg;
                        ins_next.id   = run_id_reg;
                        ins_next.prio = run_prio_reg;
                        pos_next      = len_m1;
                        rd_addr       = head_reg + len_m1[TW-1:0];
                        state_next    = (len_m1 == '0) ? S_PLACE : S_INS;
                    end
                    status_next[rd_data_reg.id] = prqd_pkg::ST_RUNNING;
                    head_next      = head_reg + TW'(1);
                    len_next       = len_m1;
                    run_id_next    = rd_data_reg.id;
                    run_prio_next  = rd_data_reg.prio;
                    run_valid_next = 1'b1;
                    sw_next        = 1'b1;
                end
            end

            // load the result register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    cur_task_next  = run_valid_reg ? run_id_reg : '0;
                    cur_valid_next = run_valid_reg;
                    switched_next  = sw_reg;
                    preempted_next = pre_reg;
                    pre_task_next  = pre_id_reg;
                    accepted_next  = acc_reg;
                    count_next     = len_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            en_reg        <= 1'b0;
            func_reg      <= prqd_pkg::FN_ACTIVATE;
            tid_reg       <= '0;
            head_reg      <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            ins_reg       <= '0;
            for (int i = 0; i < prqd_pkg::TASK_COUNT; i++)
                status_reg[i] <= prqd_pkg::ST_SUSPENDED;
            run_id_reg    <= '0;
            run_prio_reg  <= '0;
            run_valid_reg <= 1'b0;
            sw_reg        <= 1'b0;
            pre_reg       <= 1'b0;
            pre_id_reg    <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_task_reg  <= '0;
            cur_valid_reg <= 1'b0;
            switched_reg  <= 1'b0;
            preempted_reg <= 1'b0;
            pre_task_reg  <= '0;
            accepted_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
                en_reg    <= cfg_wdata;
            func_reg      <= func_next;
            tid_reg       <= tid_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            ins_reg       <= ins_next;
            status_reg    <= status_next;
            run_id_reg    <= run_id_next;
            run_prio_reg  <= run_prio_next;
            run_valid_reg <= run_valid_next;
            sw_reg        <= sw_next;
            pre_reg       <= pre_next;
            pre_id_reg    <= pre_id_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            cur_task_reg  <= cur_task_next;
            cur_valid_reg <= cur_valid_next;
            switched_reg  <= switched_next;
            preempted_reg <= preempted_next;
            pre_task_reg  <= pre_task_next;
            accepted_reg  <= accepted_next;
            count_reg     <= count_next;
        end
    end

    // Ready list memory; read and write never hit the same live entry in one cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            list_mem[wr_addr] <= wr_data;
        rd_data_reg <= list_mem[rd_addr];
    end

    // Ports
    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign current_task   = cur_task_reg;
    assign current_valid  = cur_valid_reg;
    assign switched       = switched_reg;
    assign preempted      = preempted_reg;
    assign preempted_task = pre_task_reg;
    assign accepted       = accepted_reg;
    assign ready_count    = count_reg;

    // Checks
    `PRQD_ASSERT(a_run_status, run_valid_reg,
        status_reg[run_id_reg] == prqd_pkg::ST_RUNNING,
        "running task does not hold running status")
    `PRQD_ASSERT(a_len_bound, state_reg == S_IDLE,
        len_reg <= CW'(prqd_pkg::TASK_COUNT),
        "ready list longer than task count")
    `PRQD_ASSERT(a_preempt_switch, out_valid_reg && preempted_reg,
        switched_reg && cur_valid_reg && cur_task_reg != pre_task_reg,
        "preemption without a switch to another task")
    `PRQD_ASSERT_NEXT(a_out_drain, out_valid_reg && !out_stall && state_reg != S_DONE,
        !out_valid_reg,
        "result repeated after its transfer")

endmodule

`default_nettype wire

FILE: tb/sv/prqd_schedule_scoreboard.sv
// Scoreboard for the ready queue dispatcher: follows the enable register and both
// transfer channels, predicts each result and compares it field by field.
// Depends on prqd_pkg.
module prqd_schedule_scoreboard
    import prqd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [TASK_W-1:0]    task_id,
    input  logic [PRIO_BITS-1:0] priority_req,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [TASK_W-1:0]    current_task,
    input  logic                 current_valid,
    input  logic                 switched,
    input  logic                 preempted,
    input  logic [TASK_W-1:0]    preempted_task,
    input  logic                 accepted,
    input  logic [CNT_W-1:0]     ready_count,
    output int                   fail_count,
    output int                   pending,
    output int                   checked
);

    // One result transfer as the block should present it
    typedef struct packed {
        logic [TASK_W-1:0] cur_task;
        logic              cur_valid;
        logic              switched;
        logic              preempted;
        logic [TASK_W-1:0] pre_task;
        logic              accepted;
        logic [CNT_W-1:0]  count;
    } sched_outcome_t;

    // Shadow of the scheduler
    logic                 sched_on;
    status_t              status_tab [TASK_COUNT];
    logic [PRIO_BITS-1:0] prio_tab   [TASK_COUNT];
    logic [TASK_W-1:0]    ready_list [$];
    logic [TASK_W-1:0]    run_id;
    logic                 run_valid;
    sched_outcome_t       awaited_outcomes [$];

    // Insert by priority, behind every entry of equal priority; no duplicates
    function automatic void list_enqueue(logic [TASK_W-1:0] id);
        int pos;
        foreach (ready_list[i])
            if (ready_list[i] == id)
                return;
        if (ready_list.size() >= TASK_COUNT)
            return;
        pos = ready_list.size();
        while (pos > 0 && prio_tab[ready_list[pos-1]] > prio_tab[id])
            pos--;
        ready_list.insert(pos, id);
    endfunction

    // Take a task out of the list, closing the gap
    function automatic bit list_take(logic [TASK_W-1:0] id);
        foreach (ready_list[i])
            if (ready_list[i] == id) begin
                ready_list.delete(i);
                return 1'b1;
            end
        return 1'b0;
    endfunction

    // Start the head; a running task is requeued first
    function automatic void run_head(inout sched_outcome_t r);
        logic [TASK_W-1:0] next_id;
        if (ready_list.size() == 0) begin
            // empty list: go idle, the old task keeps its running status
            run_valid = 1'b0;
            return;
        end
        next_id = ready_list[0];
        if (run_valid && next_id == run_id)
            return;
        if (run_valid && status_tab[run_id] == ST_RUNNING) begin
            status_tab[run_id] = ST_READY;
            list_enqueue(run_id);
            r.preempted = 1'b1;
            r.pre_task  = run_id;
        end
        void'(list_take(next_id));
        run_id             = next_id;
        run_valid          = 1'b1;
        status_tab[next_id] = ST_RUNNING;
        r.switched         = 1'b1;
    endfunction

    // Apply one request to the shadow and return the result it should give
    function automatic sched_outcome_t next_schedule(func_t op, logic [TASK_W-1:0] id,
                                                     logic [PRIO_BITS-1:0] prio);
        sched_outcome_t r;
        r = '0;
        case (op)
            FN_ACTIVATE:
                if (sched_on && status_tab[id] == ST_SUSPENDED
                        && ready_list.size() < TASK_COUNT) begin
                    status_tab[id] = ST_READY;
                    prio_tab[id]   = prio;
                    list_enqueue(id);
                    r.accepted = 1'b1;
                end
            FN_REMOVE:
                // status is left alone, a ready task drops out of the list
                r.accepted = list_take(id);
            FN_DISPATCH:
                run_head(r);
            default:
                // leave interrupt: only when idle or the head is strictly better
                if (ready_list.size() > 0 && (!run_valid ||
                        (ready_list[0] != run_id &&
                         prio_tab[ready_list[0]] < prio_tab[run_id])))
                    run_head(r);
        endcase
        r.cur_task  = run_valid ? run_id : '0;
        r.cur_valid = run_valid;
        r.count     = CNT_W'(ready_list.size());
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Track configuration, requests and results
    always @(posedge clk or negedge rst_n) begin : track
        sched_outcome_t want;
        if (!rst_n) begin
            sched_on  = 1'b0;
            run_id    = '0;
            run_valid = 1'b0;
            ready_list.delete();
            awaited_outcomes.delete();
            foreach (status_tab[i]) begin
                status_tab[i] = ST_SUSPENDED;
                prio_tab[i]   = '0;
            end
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else begin
            if (cfg_we)
                sched_on = cfg_wdata;
            if (in_valid && !in_stall)
                awaited_outcomes.push_back(next_schedule(func_t'(func), task_id, priority_req));
            if (out_valid && !out_stall) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end
                else begin
                    want = awaited_outcomes.pop_front();
                    compare_field("current_task", want.cur_task, current_task);
                    compare_field("current_valid", want.cur_valid, current_valid);
                    compare_field("switched", want.switched, switched);
                    compare_field("preempted", want.preempted, preempted);
                    compare_field("preempted_task", want.pre_task, preempted_task);
                    compare_field("accepted", want.accepted, accepted);
                    compare_field("ready_count", want.count, ready_count);
                    checked++;
                end
            end
            pending = awaited_outcomes.size();
        end
    end

endmodule

FILE: tb/sv/priority_ready_queue_dispatcher_core_tb.sv
// Testbench top for the ready queue dispatcher: clock, reset, request and result
// traffic, enable register writes and the final verdict.
// Depends on prqd_pkg, the dispatcher core and prqd_schedule_scoreboard.
module priority_ready_queue_dispatcher_core_tb;
    import prqd_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    typedef enum logic {
        MIX_STEADY,
        MIX_DRAIN
    } mix_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic                 cfg_wdata    = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    func_t                func         = FN_ACTIVATE;
    logic [TASK_W-1:0]    task_id      = '0;
    logic [PRIO_BITS-1:0] priority_req = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [TASK_W-1:0]    current_task;
    logic                 current_valid;
    logic                 switched;
    logic                 preempted;
    logic [TASK_W-1:0]    preempted_task;
    logic                 accepted;
    logic [CNT_W-1:0]     ready_count;

    int fail_count;
    int pending;
    int checked;
    int sent        = 0;
    int burst_left  = 0;
    int cycle_count = 0;
    bit hold_wanted = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    priority_ready_queue_dispatcher_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .task_id        (task_id),
        .priority_req   (priority_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .current_task   (current_task),
        .current_valid  (current_valid),
        .switched       (switched),
        .preempted      (preempted),
        .preempted_task (preempted_task),
        .accepted       (accepted),
        .ready_count    (ready_count)
    );

    prqd_schedule_scoreboard sched_sb (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .task_id        (task_id),
        .priority_req   (priority_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .current_task   (current_task),
        .current_valid  (current_valid),
        .switched       (switched),
        .preempted      (preempted),
        .preempted_task (preempted_task),
        .accepted       (accepted),
        .ready_count    (ready_count),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked)
    );

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One request transfer, in bursts with random gaps between them
    task automatic issue(input func_t f, input logic [TASK_W-1:0] t,
                         input logic [PRIO_BITS-1:0] p);
        int   gap;
        logic stalled;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        func         <= f;
        task_id      <= t;
        priority_req <= p;
        // stall is sampled mid-cycle, the transfer happens at the next edge
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        sent++;
    endtask

    // Stop sending and wait for every outstanding result, then a margin
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_enable(input logic on);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Steady mix keeps tasks in circulation; removals there hit only the tasks
    // already spent by the opening, since a removed task never comes back.
    // The drain mix removes freely.
    task automatic random_item(input mix_t mix);
        int                   roll;
        logic [TASK_W-1:0]    id;
        logic [PRIO_BITS-1:0] prio;
        roll = $urandom_range(0, 99);
        id   = TASK_W'($urandom);
        // half the priorities from a coarse set so that ties are common
        prio = $urandom_range(0, 1) ? PRIO_BITS'($urandom)
                                    : PRIO_BITS'($urandom_range(0, 3) * 64);
        if (mix == MIX_STEADY) begin
            if (roll < 25)
                issue(FN_ACTIVATE, id, prio);
            else if (roll < 30)
                issue(FN_REMOVE, TASK_W'($urandom_range(13, 15)), prio);
            else if (roll < 65)
                issue(FN_DISPATCH, id, prio);
            else
                issue(FN_LEAVE, id, prio);
        end
        else begin
            if (roll < 10)
                issue(FN_ACTIVATE, id, prio);
            else if (roll < 50)
                issue(FN_REMOVE, id, prio);
            else if (roll < 80)
                issue(FN_DISPATCH, id, prio);
            else
                issue(FN_LEAVE, id, prio);
        end
    endtask

    // Request side: reset, directed opening, random phases, verdict
    initial begin : request_side
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scheduler still disabled
        issue(FN_ACTIVATE, 4'd0, 8'd5);     // refused
        issue(FN_DISPATCH, 4'd0, 8'd0);     // empty list, stays idle
        issue(FN_LEAVE, 4'd0, 8'd0);        // nothing ready
        issue(FN_REMOVE, 4'd3, 8'd0);       // not in the list
        settle();
        set_enable(1'b1);

        issue(FN_ACTIVATE, 4'd15, 8'd255);
        issue(FN_LEAVE, 4'd0, 8'd0);        // idle, so 15 starts
        issue(FN_LEAVE, 4'd0, 8'd0);        // list empty
        issue(FN_DISPATCH, 4'd0, 8'd0);     // empty list: idle, 15 left running
        issue(FN_ACTIVATE, 4'd15, 8'd3);    // refused, not suspended
        issue(FN_ACTIVATE, 4'd14, 8'd0);
        issue(FN_ACTIVATE, 4'd13, 8'd0);    // tie, goes behind 14
        issue(FN_LEAVE, 4'd0, 8'd0);        // idle, 14 starts
        issue(FN_LEAVE, 4'd0, 8'd0);        // equal priority, no switch
        issue(FN_ACTIVATE, 4'd12, 8'd128);
        issue(FN_DISPATCH, 4'd0, 8'd0);     // 14 preempted, 13 runs
        issue(FN_REMOVE, 4'd14, 8'd0);      // ready but out of the list
        issue(FN_ACTIVATE, 4'd14, 8'd1);    // refused, still ready
        issue(FN_REMOVE, 4'd14, 8'd0);      // already gone
        issue(FN_DISPATCH, 4'd0, 8'd0);     // worse task 12 runs anyway
        issue(FN_LEAVE, 4'd0, 8'd0);        // 13 strictly better, preempts
        issue(FN_ACTIVATE, 4'd1, 8'd200);
        issue(FN_ACTIVATE, 4'd2, 8'd128);   // tie with 12, behind it
        issue(FN_REMOVE, 4'd7, 8'd0);       // suspended task
        issue(FN_ACTIVATE, 4'd0, 8'd85);
        settle();

        repeat (350) random_item(MIX_STEADY);
        settle();
        set_enable(1'b0);
        repeat (80) random_item(MIX_STEADY);
        settle();
        set_enable(1'b1);
        // long result hold-off while requests keep coming
        hold_wanted = 1'b1;
        repeat (350) random_item(MIX_STEADY);
        repeat (60) random_item(MIX_DRAIN);
        settle();

        @(negedge clk);
        $display("Run: %0d requests (24 directed), %0d results compared, in %0d cycles.",
                 sent, checked, cycle_count);
        $display("Covered enable off and on, a %0d-cycle result hold-off and a final drain.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: stall patterns of its own, one long hold-off on request
    initial begin : result_side
        int mode;
        int span;
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_wanted && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            for (int k = 0; k < span; k++) begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ((k % 8) < 5);
                endcase
                @(posedge clk);
            end
        end
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/prqd_pkg.sv
hdl/priority_ready_queue_dispatcher_core.sv
tb/sv/prqd_schedule_scoreboard.sv
tb/sv/priority_ready_queue_dispatcher_core_tb.sv
